### rtl/core/snu_pkg.sv
// ---------------------------------------------------------------------------
// snu_pkg: shared types and constants of the surface normal unit
// Widths of coordinates, edges, cross product, squared length and results.
// ---------------------------------------------------------------------------
`default_nettype none
package snu_pkg;
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 15;
    localparam int OUT_BITS   = FRAC_BITS + 1;
    localparam int BIT_BITS   = $clog2(OUT_BITS);
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * EDGE_BITS;
    localparam int NRM_BITS   = PROD_BITS + 1;
    localparam int MAG_BITS   = PROD_BITS;
    localparam int SQ_BITS    = 2 * MAG_BITS + 2;
    // Squared numerator scaled by 2^(2*FRAC_BITS).
    localparam int TGT_BITS   = 2 * MAG_BITS + 2 * FRAC_BITS;
    // Running product q * s of one lane.
    localparam int SQQ_BITS   = SQ_BITS + OUT_BITS;
    // Width of the trial term compared against the remainder.
    localparam int CMP_BITS   = SQQ_BITS + OUT_BITS + 1;
    localparam int CELLS      = OUT_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [MAG_BITS-1:0]          t_mag;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [TGT_BITS-1:0]          t_tgt;
    typedef logic [SQQ_BITS-1:0]          t_sqq;
    typedef logic [OUT_BITS-1:0]          t_q;

    // One lane's worth of data moving down the cell chain.
    typedef struct packed {
        t_tgt rem;
        t_sqq sq;
        t_q   q;
        logic neg;
    } t_lane;

    typedef struct packed {
        logic  vld;
        logic  dgn;
        t_sq   s;
        t_lane [2:0] ln;
    } t_word;
endpackage
`default_nettype wire

### rtl/core/snu_front.sv
// ---------------------------------------------------------------------------
// snu_front: edge vectors, cross product and squared length
// Register stages that turn corner points into one chain word.
// ---------------------------------------------------------------------------
`default_nettype none
module snu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire snu_pkg::t_coord i_p1 [3],
    input  wire snu_pkg::t_coord i_p2 [3],
    input  wire snu_pkg::t_coord i_p3 [3],
    output snu_pkg::t_word       o_word
);
    import snu_pkg::*;

    logic signed [EDGE_BITS-1:0] r_a [3];
    logic signed [EDGE_BITS-1:0] r_b [3];
    logic signed [PROD_BITS-1:0] r_pp [6];
    logic signed [NRM_BITS-1:0]  r_n [3];
    logic [2:0] r_vld;
    t_mag w_m [3];
    logic [2*MAG_BITS-1:0] w_sq [3];
    t_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
        for (int i = 0; i < 3; i++) begin
            r_a[i] <= EDGE_BITS'(i_p3[i]) - EDGE_BITS'(i_p2[i]);
            r_b[i] <= EDGE_BITS'(i_p1[i]) - EDGE_BITS'(i_p2[i]);
        end
        r_pp[0] <= r_a[1] * r_b[2];
        r_pp[1] <= r_a[2] * r_b[1];
        r_pp[2] <= r_a[2] * r_b[0];
        r_pp[3] <= r_a[0] * r_b[2];
        r_pp[4] <= r_a[0] * r_b[1];
        r_pp[5] <= r_a[1] * r_b[0];
        for (int i = 0; i < 3; i++) begin
            r_n[i] <= NRM_BITS'(r_pp[2*i]) - NRM_BITS'(r_pp[2*i+1]);
        end
    end

    // |N_i| fits in MAG_BITS since the cross product of 13-bit edges is bounded.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m[i]  = r_n[i][NRM_BITS-1] ? MAG_BITS'(-r_n[i]) : MAG_BITS'(r_n[i]);
            w_sq[i] = w_m[i] * w_m[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= r_vld[2];
        end
        r_word.s <= SQ_BITS'(w_sq[0]) + SQ_BITS'(w_sq[1]) + SQ_BITS'(w_sq[2]);
        r_word.dgn <= (w_m[0] == '0) && (w_m[1] == '0) && (w_m[2] == '0);
        for (int i = 0; i < 3; i++) begin
            r_word.ln[i].rem <= TGT_BITS'(w_sq[i]) << (2 * FRAC_BITS);
            r_word.ln[i].sq  <= '0;
            r_word.ln[i].q   <= '0;
            r_word.ln[i].neg <= r_n[i][NRM_BITS-1];
        end
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

### rtl/core/snu_cell.sv
// ---------------------------------------------------------------------------
// snu_cell: one quotient bit of the normalized components
// Each lane carries rem = target - q^2*s and sq = q*s, so trying a bit needs
// only shifts, one add and one compare.
// ---------------------------------------------------------------------------
`default_nettype none
module snu_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [snu_pkg::BIT_BITS-1:0]  i_bit,
    input  wire snu_pkg::t_word                i_word,
    output snu_pkg::t_word                     o_word
);
    import snu_pkg::*;

    t_word r_word;
    t_q    w_t [3];
    logic [CMP_BITS-1:0] w_need [3];
    logic  w_fit [3];

    // (q + 2^b)^2 * s - q^2 * s = 2^(b+1) * q*s + 2^(2b) * s.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_t[i]    = i_word.ln[i].q | (t_q'(1) << i_bit);
            w_need[i] = (CMP_BITS'(i_word.ln[i].sq) << (i_bit + 1))
                      + (CMP_BITS'(i_word.s) << (2 * i_bit));
            w_fit[i]  = w_need[i] <= CMP_BITS'(i_word.ln[i].rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= i_word.vld;
        end
        r_word.s   <= i_word.s;
        r_word.dgn <= i_word.dgn;
        for (int i = 0; i < 3; i++) begin
            r_word.ln[i].neg <= i_word.ln[i].neg;
            if (w_fit[i]) begin
                r_word.ln[i].rem <= i_word.ln[i].rem - TGT_BITS'(w_need[i]);
                r_word.ln[i].sq  <= i_word.ln[i].sq + (SQQ_BITS'(i_word.s) << i_bit);
                r_word.ln[i].q   <= w_t[i];
            end else begin
                r_word.ln[i].rem <= i_word.ln[i].rem;
                r_word.ln[i].sq  <= i_word.ln[i].sq;
                r_word.ln[i].q   <= i_word.ln[i].q;
            end
        end
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

### rtl/core/surface_normal_unit_top.sv
// ---------------------------------------------------------------------------
// surface_normal_unit_top: unit normal of a triangle in signed Q1.15
// Cross product, squared length and a chain of bit cells for N_i/|N|.
// ---------------------------------------------------------------------------
//  channel   | ports                               | handshake
//  command   | i_first_* i_second_* i_third_*      | i_start, o_busy (always 0)
//  result    | o_unit_x/y/z, o_degenerate          | o_done strobe, one cycle
//
// A word enters every cycle and passes 4 + 16 + 1 = 21 register stages: the
// three front stages, the squared-length stage, one cell per quotient bit and
// the output register. The first stage captures at the accepting edge, and
// o_done is driven from the output register. Synchronous reset clears all valid bits.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module surface_normal_unit_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    output logic                 o_busy,
    input  wire snu_pkg::t_coord i_first_x,
    input  wire snu_pkg::t_coord i_first_y,
    input  wire snu_pkg::t_coord i_first_z,
    input  wire snu_pkg::t_coord i_second_x,
    input  wire snu_pkg::t_coord i_second_y,
    input  wire snu_pkg::t_coord i_second_z,
    input  wire snu_pkg::t_coord i_third_x,
    input  wire snu_pkg::t_coord i_third_y,
    input  wire snu_pkg::t_coord i_third_z,
    output logic                 o_done,
    output logic signed [snu_pkg::OUT_BITS-1:0] o_unit_x,
    output logic signed [snu_pkg::OUT_BITS-1:0] o_unit_y,
    output logic signed [snu_pkg::OUT_BITS-1:0] o_unit_z,
    output logic                 o_degenerate
);
    import snu_pkg::*;

    t_coord w_p1 [3];
    t_coord w_p2 [3];
    t_coord w_p3 [3];
    t_word  w_chain [CELLS+1];
    t_q     w_res [3];
    logic   r_done;
    logic   r_dgn;
    t_q     r_u [3];

    assign o_busy = 1'b0;
    assign w_p1 = '{i_first_x, i_first_y, i_first_z};
    assign w_p2 = '{i_second_x, i_second_y, i_second_z};
    assign w_p3 = '{i_third_x, i_third_y, i_third_z};

    snu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_start && !o_busy),
        .i_p1(w_p1), .i_p2(w_p2), .i_p3(w_p3), .o_word(w_chain[0])
    );

    // Cell k decides quotient bit FRAC_BITS - k, most significant first.
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        snu_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_bit(BIT_BITS'(FRAC_BITS - k)),
            .i_word(w_chain[k]), .o_word(w_chain[k+1])
        );
    end

    // Degenerate words have s = 0, so every trial passes; they are zeroed here.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_chain[CELLS].dgn) begin
                w_res[i] = '0;
            end else if (w_chain[CELLS].ln[i].neg) begin
                w_res[i] = -w_chain[CELLS].ln[i].q;
            end else if (w_chain[CELLS].ln[i].q[OUT_BITS-1]) begin
                w_res[i] = {1'b0, {(OUT_BITS-1){1'b1}}};
            end else begin
                w_res[i] = w_chain[CELLS].ln[i].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_chain[CELLS].vld;
        end
        r_dgn <= w_chain[CELLS].dgn;
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= w_res[i];
        end
    end

    assign o_done       = r_done;
    assign o_degenerate = r_dgn;
    assign o_unit_x     = r_u[0];
    assign o_unit_y     = r_u[1];
    assign o_unit_z     = r_u[2];

    a_dgn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_degenerate |-> (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0))
        else $error("degenerate result not zero");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[0].vld |-> ##(CELLS+1) o_done)
        else $error("word lost in chain");
    a_nodone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_chain[0].vld |-> ##(CELLS+1) !o_done)
        else $error("spurious done");
endmodule
`default_nettype wire

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the surface normal unit
// Drives triangles with random pauses, predicts each unit normal with exact
// integer arithmetic, and compares every strobed result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import snu_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        t_coord [8:0] pts;   // first xyz, second xyz, third xyz
        bit           wait_empty;
        int           gap;
    } t_tri_word;

    typedef struct {
        logic signed [OUT_BITS-1:0] ux, uy, uz;
        logic                       dgn;
    } t_normal;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_start = 1'b0;
    t_coord i_fx = '0, i_fy = '0, i_fz = '0;
    t_coord i_sx = '0, i_sy = '0, i_sz = '0;
    t_coord i_tx = '0, i_ty = '0, i_tz = '0;
    logic   o_busy, o_done, o_degenerate;
    logic signed [OUT_BITS-1:0] o_unit_x, o_unit_y, o_unit_z;

    t_tri_word pending_tris[$];
    t_normal   normal_q[$];
    int        gap_left = 0;
    int        idle_cycles = 0;
    int        errors = 0;

    surface_normal_unit_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_first_x(i_fx), .i_first_y(i_fy), .i_first_z(i_fz),
        .i_second_x(i_sx), .i_second_y(i_sy), .i_second_z(i_sz),
        .i_third_x(i_tx), .i_third_y(i_ty), .i_third_z(i_tz),
        .o_done(o_done), .o_unit_x(o_unit_x), .o_unit_y(o_unit_y),
        .o_unit_z(o_unit_z), .o_degenerate(o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    // Largest q with q*q*s <= n*n*2^(2*FRAC_BITS), i.e. floor(|n|*2^F/sqrt(s)).
    function automatic logic [127:0] scaled_quotient(longint unsigned nabs,
                                                     longint unsigned s);
        logic [127:0] target, q, t, s_w, prod;
        target = 128'(nabs) * 128'(nabs);
        target = target << (2 * FRAC_BITS);
        s_w = 128'(s);
        q = '0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            t = q | (128'd1 << b);
            prod = t * t * s_w;
            if (prod <= target)
                q = t;
        end
        return q;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] to_q15(longint n, longint unsigned s);
        longint unsigned nabs;
        logic [127:0] q;
        nabs = (n < 0) ? longint'(-n) : longint'(n);
        q = scaled_quotient(nabs, s);
        if (n < 0)
            return OUT_BITS'(-q);
        if (q >= (128'd1 << FRAC_BITS))
            q = (128'd1 << FRAC_BITS) - 1;
        return OUT_BITS'(q);
    endfunction

    function automatic t_normal unit_normal(t_coord [8:0] p);
        longint a[3], b[3], n[3];
        longint unsigned s;
        t_normal r;
        for (int i = 0; i < 3; i++) begin
            a[i] = longint'(p[6+i]) - longint'(p[3+i]);
            b[i] = longint'(p[i]) - longint'(p[3+i]);
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        s = 0;
        for (int i = 0; i < 3; i++)
            s += longint'(n[i] * n[i]);
        if (s == 0) begin
            r.ux = '0; r.uy = '0; r.uz = '0; r.dgn = 1'b1;
        end else begin
            r.ux = to_q15(n[0], s);
            r.uy = to_q15(n[1], s);
            r.uz = to_q15(n[2], s);
            r.dgn = 1'b0;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_tri(int fx, int fy, int fz, int sx, int sy, int sz,
                           int tx, int ty, int tz, bit wait_empty = 0);
        t_tri_word w;
        w.pts = {t_coord'(tz), t_coord'(ty), t_coord'(tx),
                 t_coord'(sz), t_coord'(sy), t_coord'(sx),
                 t_coord'(fz), t_coord'(fy), t_coord'(fx)};
        w.wait_empty = wait_empty;
        w.gap = pick_gap();
        pending_tris.push_back(w);
    endtask

    // Driver: a word is taken at an edge where start is high and busy low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_start && !o_busy)
                normal_q.push_back(unit_normal({i_tz, i_ty, i_tx, i_sz, i_sy, i_sx,
                                                i_fz, i_fy, i_fx}));
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_start <= 1'b0;
                end else if (pending_tris.size() > 0 &&
                             !(pending_tris[0].wait_empty && normal_q.size() > 0)) begin
                    {i_tz, i_ty, i_tx, i_sz, i_sy, i_sx, i_fz, i_fy, i_fx}
                        <= pending_tris[0].pts;
                    gap_left <= pending_tris[0].gap;
                    i_start <= 1'b1;
                    void'(pending_tris.pop_front());
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so each strobe is checked at once.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (normal_q.size() == 0) begin
                $display("%0t: result with nothing expected: x=%0d y=%0d z=%0d dgn=%0b",
                         $time, o_unit_x, o_unit_y, o_unit_z, o_degenerate);
                errors++;
            end else begin
                t_normal e;
                e = normal_q.pop_front();
                if (o_unit_x !== e.ux || o_unit_y !== e.uy || o_unit_z !== e.uz ||
                    o_degenerate !== e.dgn) begin
                    $display("%0t: mismatch expected x=%0d y=%0d z=%0d dgn=%0b",
                             $time, e.ux, e.uy, e.uz, e.dgn);
                    $display("%0t:          actual   x=%0d y=%0d z=%0d dgn=%0b",
                             $time, o_unit_x, o_unit_y, o_unit_z, o_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int lim, bx, by, bz;
        // Degenerate: all points equal, collinear, and two corners shared.
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(1, 1, 1, 2, 2, 2, 3, 3, 3);
        add_tri(-2048, 2047, 5, -2048, 2047, 5, 100, -7, 3);
        // Axis-aligned triangles: components of exactly minus one and saturated plus one.
        add_tri(0, 1, 0, 0, 0, 0, 1, 0, 0);
        add_tri(1, 0, 0, 0, 0, 0, 0, 1, 0);
        add_tri(0, 0, 1, 0, 0, 0, 0, 1, 0);
        add_tri(0, 1, 0, 0, 0, 0, 0, 0, 1);
        add_tri(0, 0, 1, 0, 0, 0, 1, 0, 0);
        add_tri(1, 0, 0, 0, 0, 0, 0, 0, 1);
        // Field extremes, largest cross products.
        add_tri(2047, -2048, -2048, -2048, -2048, -2048, -2048, 2047, -2048);
        add_tri(-2048, 2047, 2047, 2047, -2048, 2047, 2047, 2047, -2048);
        add_tri(2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 2047);
        add_tri(-2048, -2048, 2047, 2047, 2047, -2048, -2048, 2047, 2047);
        // Tiny negative component that truncates to zero.
        add_tri(2046, 2045, -2048, -2048, -2048, 0, 2047, 2046, 2047);
        add_tri(2045, 2046, -2048, -2048, -2048, 0, 2046, 2047, 2047);
        add_tri(1, 2, 3, -1, -1, -1, 4, -5, 6);

        lim = 2047;
        for (int k = 0; k < 500; k++) begin
            bit drain;
            drain = (k == 150) || (k == 400);
            case ($urandom_range(0, 3))
                0: lim = 2047;
                1: lim = 8;
                2: lim = 1;
                default: lim = $urandom_range(16, 600);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                // Collinear points: first halfway from second to third.
                bx = $urandom_range(0, 2 * lim) - lim;
                by = $urandom_range(0, 2 * lim) - lim;
                bz = $urandom_range(0, 2 * lim) - lim;
                add_tri(bx / 2, by / 2, bz / 2, 0, 0, 0,
                        2 * (bx / 2), 2 * (by / 2), 2 * (bz / 2), drain);
            end else begin
                add_tri($urandom_range(0, 2 * lim) - lim, $urandom_range(0, 2 * lim) - lim,
                        $urandom_range(0, 2 * lim) - lim, $urandom_range(0, 2 * lim) - lim,
                        $urandom_range(0, 2 * lim) - lim, $urandom_range(0, 2 * lim) - lim,
                        $urandom_range(0, 2 * lim) - (lim + (lim == 2047)),
                        $urandom_range(0, 2 * lim) - (lim + (lim == 2047)),
                        $urandom_range(0, 2 * lim) - (lim + (lim == 2047)), drain);
            end
            // Back-to-back stretches with no pauses.
            if ((k / 60) % 3 == 1)
                pending_tris[$].gap = 0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            if (pending_tris.size() == 0 && !i_start && normal_q.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && normal_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
